// ----- rtl/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int PRIO_W           = 16;
    localparam int DATA_W           = 32;
    localparam int OCC_W            = 5;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [DATA_W-1:0]        payload;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry, shifts it right on push, left on pop.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     left_entry,
    input  logic       left_valid,
    input  logic       left_keep,
    input  entry_t     right_entry,
    input  logic       right_valid,
    output entry_t     entry,
    output logic       valid,
    output logic       keep
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    // An entry stays put when it outranks or ties the new one.
    assign keep = valid_reg &&
                  ($signed(entry_reg.prio) >= $signed(ctrl.new_entry.prio));

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        priority if (ctrl.push)
        begin
            valid_next = valid_reg | left_valid;
            priority if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = ctrl.new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
        else
        begin
            // Hold the slot when no operation moves the chain.
            entry_next = entry_reg;
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

// ----- rtl/stable_priority_queue.sv -----
// Top level of the stable priority queue: a sorted chain of cells and the result register.
//
//  channel   ports                                       transfer when
//  command   start, busy, action, priority_req, payload   start && !busy at clk rise
//  result    done, result_payload, status, occupancy      done high, one cycle
//
//  One command per cycle; its result appears in the cycle after acceptance.
//  Every cell compares against the pushed priority at once, and all cells shift on the same clock edge.
//  busy stays low: the chain finishes any operation without stalling a command.
//  rst_n clears the valid bits, the count, the strobe and the result registers; slot contents need no reset.
//  The receiver cannot stall, so results are never held back.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     action,
    input  logic signed [PRIO_W-1:0] priority_req,
    input  logic [DATA_W-1:0]        payload,
    output logic                     done,
    output logic [DATA_W-1:0]        result_payload,
    output logic [1:0]               status,
    output logic [OCC_W-1:0]         occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctrl_t          ctrl;
    entry_t              cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_keep;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    logic [DATA_W-1:0]   result_payload_reg;
    logic [DATA_W-1:0]   result_payload_next;
    status_t             status_reg;
    status_t             status_next;
    logic [OCC_W-1:0]    occupancy_reg;
    logic [CNT_W+OCC_W-1:0] count_ext;

    logic accept;
    logic is_full;
    logic is_empty;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = cell_valid[CAPACITY-1];
    assign is_empty = !cell_valid[0];

    always_comb
    begin
        ctrl.push                   = accept && (action == ACT_PUSH) && !is_full;
        ctrl.pop                    = accept && (action == ACT_POP) && !is_empty;
        ctrl.new_entry.prio         = priority_req;
        ctrl.new_entry.payload      = payload;
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            entry_t left_entry;
            logic   left_valid;
            logic   left_keep;
            entry_t right_entry;
            logic   right_valid;

            if (i == 0)
            begin : g_head
                // Head has a virtual keeping neighbor, so a new top entry lands here.
                assign left_entry = ctrl.new_entry;
                assign left_valid = 1'b1;
                assign left_keep  = 1'b1;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[i-1];
                assign left_valid = cell_valid[i-1];
                assign left_keep  = cell_keep[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_entry = cell_entry[i];
                assign right_valid = 1'b0;
            end
            else
            begin : g_mid
                assign right_entry = cell_entry[i+1];
                assign right_valid = cell_valid[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_entry  (left_entry),
                .left_valid  (left_valid),
                .left_keep   (left_keep),
                .right_entry (right_entry),
                .right_valid (right_valid),
                .entry       (cell_entry[i]),
                .valid       (cell_valid[i]),
                .keep        (cell_keep[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next          = count_reg;
        result_payload_next = '0;
        status_next         = ST_DONE;
        unique case (action)
            ACT_PUSH:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            ACT_POP:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                begin
                    count_next          = count_reg - CNT_W'(1);
                    result_payload_next = cell_entry[0].payload;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Report occupancy masked to the field width.
    assign count_ext = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg          <= '0;
            done_reg           <= 1'b0;
            result_payload_reg <= '0;
            status_reg         <= ST_DONE;
            occupancy_reg      <= '0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg          <= count_next;
                result_payload_reg <= result_payload_next;
                status_reg         <= status_next;
                occupancy_reg      <= count_ext[OCC_W-1:0];
            end
        end
    end

    assign done           = done_reg;
    assign result_payload = result_payload_reg;
    assign status         = status_reg;
    assign occupancy      = occupancy_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(cell_valid))
        else $error("entry count disagrees with valid cells");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid == CAPACITY'((CAPACITY+1)'(1) << count_reg) - CAPACITY'(1)
        || cell_valid == '1)
        else $error("valid cells are not a contiguous prefix");

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted command produced no result");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg != ST_DONE) |-> result_payload == '0)
        else $error("refused operation returned a payload");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid[0] && cell_valid[1 % CAPACITY] && CAPACITY > 1) |->
        ($signed(cell_entry[0].prio) >= $signed(cell_entry[1 % CAPACITY].prio)))
        else $error("head cell outranked by its neighbor");

endmodule
